@@ design/dlm_pkg.sv @@
`default_nettype none

package dlm_pkg;

  // Fixed field and datapath widths
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;
  localparam int CNT_W  = 7;

  // Element counter saturates here
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  // Register reset values
  localparam logic [6:0] INPUTS_RST  = 7'd64;
  localparam logic [4:0] OUTPUTS_RST = 5'd16;

  // Input word kinds (carried on tuser)
  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_ELEMENT = 2'd2
  } dlm_op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_INPUTS  = 2'd0,
    REG_OUTPUTS = 2'd1
  } dlm_reg_t;

  // One input element handed to the MAC engine
  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic                    first;
    logic                    use_elem;
    logic                    last;
    logic                    size_err;
  } dlm_cmd_t;

  // One result row
  typedef struct packed {
    logic [3:0]              index;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
    logic                    size_err;
    logic                    eov;
  } dlm_res_t;

endpackage

`default_nettype wire

@@ design/dlm_param_store.sv @@
`default_nettype none

module dlm_param_store
  import dlm_pkg::*;
#(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 16,
  localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
  localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
  input  wire logic                 clk,
  // weight write
  input  wire logic                 w_we,
  input  wire logic [RW-1:0]        w_row,
  input  wire logic [CW-1:0]        w_col,
  input  wire logic [VAL_W-1:0]     w_data,
  // bias write
  input  wire logic                 b_we,
  input  wire logic [RW-1:0]        b_row,
  input  wire logic [VAL_W-1:0]     b_data,
  // read port, registered data
  input  wire logic [RW-1:0]        rd_row,
  input  wire logic [CW-1:0]        rd_col,
  output logic      [VAL_W-1:0]     rd_weight,
  output logic      [VAL_W-1:0]     rd_bias
);

  localparam int WDEPTH = 1 << (RW + CW);

  logic [VAL_W-1:0] weight_mem [WDEPTH];
  logic [VAL_W-1:0] bias_mem   [MAX_OUTPUTS];

  // weight memory: row-major, {row, col}
  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[{w_row, w_col}] <= w_data;
    end
    rd_weight <= weight_mem[{rd_row, rd_col}];
  end

  // bias memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[b_row] <= b_data;
    end
    rd_bias <= bias_mem[rd_row];
  end

endmodule

`default_nettype wire

@@ design/dlm_mac.sv @@
`default_nettype none

module dlm_mac
  import dlm_pkg::*;
#(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 16,
  localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
  localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // element command
  input  wire logic              start,
  input  wire dlm_cmd_t          cmd,
  input  wire logic [CW-1:0]     col,
  input  wire logic [4:0]        nout,
  output logic                   busy,
  // parameter store read port
  output logic [RW-1:0]          rd_row,
  output logic [CW-1:0]          rd_col,
  input  wire logic [VAL_W-1:0]  rd_weight,
  input  wire logic [VAL_W-1:0]  rd_bias,
  // result handoff
  output dlm_res_t               res,
  output logic                   res_valid,
  input  wire logic              res_ready
);

  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_OUTPUTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_EMIT_RD,
    S_EMIT_CALC,
    S_EMIT_HOLD
  } state_t;

  state_t state;

  dlm_cmd_t          cmd_q;
  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row;
  logic [4:0]        k;

  // read-modify-write pipeline
  logic              p1_valid;
  logic [RW-1:0]     p1_row;
  logic              p2_valid;
  logic [RW-1:0]     p2_row;
  logic signed [PROD_W-1:0] p2_prod;
  logic [ACC_W-1:0]  p2_base;

  logic [ACC_W-1:0]  acc_mem [MAX_OUTPUTS];
  logic [ACC_W-1:0]  acc_rd;
  logic [RW-1:0]     acc_raddr;

  logic signed [PROD_W-1:0] prod_c;
  logic [ACC_W-1:0]  bias_ext;
  logic [ACC_W-1:0]  base_c;
  logic [ACC_W-1:0]  sum_c;

  logic [ACC_W:0]    rnd;
  logic [28:0]       r;
  logic              sat_hi;
  logic              sat_lo;
  logic [VAL_W-1:0]  val_c;

  assign busy   = (state != S_IDLE);
  assign rd_row = row;
  assign rd_col = col_q;

  assign acc_raddr = (state == S_EMIT_RD) ? RW'(k) : row;

  // multiply and pick the starting value (bias at the first element)
  always_comb begin
    prod_c   = $signed(rd_weight) * $signed(cmd_q.x);
    bias_ext = {{(ACC_W - VAL_W - 12){rd_bias[VAL_W-1]}}, rd_bias, 12'b0};
    base_c   = cmd_q.first ? bias_ext : acc_rd;
    sum_c    = p2_base + (cmd_q.use_elem ? {{(ACC_W - PROD_W){p2_prod[PROD_W-1]}}, p2_prod}
                                         : {ACC_W{1'b0}});
  end

  // round half up to Q4.12, then clip to 16 bits
  always_comb begin
    rnd    = {acc_rd[ACC_W-1], acc_rd} + (ACC_W + 1)'(2048);
    r      = rnd[ACC_W:12];
    sat_hi = !r[28] && (r[27:15] != 13'h0000);
    sat_lo = r[28] && (r[27:15] != 13'h1fff);
    if (sat_hi) begin
      val_c = 16'h7fff;
    end else if (sat_lo) begin
      val_c = 16'h8000;
    end else begin
      val_c = r[15:0];
    end
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (p2_valid) begin
      acc_mem[p2_row] <= sum_c;
    end
    acc_rd <= acc_mem[acc_raddr];
  end

  // sequencer, pipeline control and result register
  always_ff @(posedge clk) begin
    p1_row  <= row;
    p2_row  <= p1_row;
    p2_prod <= prod_c;
    p2_base <= base_c;
    if (rst) begin
      state     <= S_IDLE;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      res_valid <= 1'b0;
      row       <= '0;
      k         <= '0;
    end else begin
      p1_valid <= (state == S_SWEEP);
      p2_valid <= p1_valid;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            col_q <= col;
            row   <= '0;
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          row <= row + 1'b1;
          if (row == ROW_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the last write-back before reading for results
          if (!p1_valid && !p2_valid) begin
            k     <= '0;
            state <= cmd_q.last ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_CALC;
        end
        S_EMIT_CALC: begin
          res.index    <= k[3:0];
          res.value    <= val_c;
          res.sat      <= sat_hi || sat_lo;
          res.size_err <= cmd_q.size_err;
          res.eov      <= (k == nout - 5'd1);
          res_valid    <= 1'b1;
          state        <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (k == nout - 5'd1) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 5'd1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/dense_layer_matvec.sv @@
// Fully connected layer y = W*x + b, Q4.12 in and out, 40-bit accumulators.
// Input stream (s_axis): tuser selects the word kind: weight write, bias
// write or input element; tlast marks the final element of a vector.
// Weight and bias writes do not hold up the next word. An input element sweeps all
// MAX_OUTPUTS accumulator rows through one shared multiplier and a
// read-modify-write pipeline on the accumulator memory; the next input word
// waits until the sweep and its write-backs are done.
// On an element with tlast the block then reads each row in use, rounds and
// saturates it and sends it on m_axis, one row at a time: the row is read
// (S_EMIT_RD), rounded and clipped into the result register (S_EMIT_CALC) and
// held there until it is handed over (S_EMIT_HOLD).
// m_axis tlast marks the last row of a vector; tuser carries the clip and
// size-error flags. A stalled receiver holds the result in the output
// register and pauses the row readout; once the last row is in that register
// the next input word is taken.
// Configuration (cfg_*) is always ready; write it only while no work is open.
// Reset (rst, synchronous) clears the element count, sets inputs_in_use 64
// and outputs_in_use 16. Weights and biases must be written before use.
`default_nettype none

module dense_layer_matvec
  import dlm_pkg::*;
#(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // row[3:0], col[9:4], value[25:10], zero
  input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
  input  wire logic        s_axis_tlast,  // last element of vector
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_index[3:0], out_value[19:4], zero
  output logic [1:0]       m_axis_tuser,  // saturated[0], size_error[1]
  output logic             m_axis_tlast,  // end of vector
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  logic [6:0]       inputs_in_use;
  logic [4:0]       outputs_in_use;
  logic [CNT_W-1:0] count;

  logic [8:0]       in9;
  logic [8:0]       eff_in;
  logic [6:0]       out7;
  logic [6:0]       out_clamp;
  logic [4:0]       eff_out;

  logic             in_fire;
  dlm_op_t          op;
  logic [3:0]       in_row;
  logic [5:0]       in_col;
  logic [VAL_W-1:0] in_val;

  logic             w_we;
  logic             b_we;
  logic             elem_go;

  logic [8:0]       cnt9;
  logic [CNT_W-1:0] cnt_inc;
  dlm_cmd_t         cmd;

  logic             mac_busy;
  logic [RW-1:0]    rd_row;
  logic [CW-1:0]    rd_col;
  logic [VAL_W-1:0] rd_weight;
  logic [VAL_W-1:0] rd_bias;
  dlm_res_t         mac_res;
  logic             mac_res_valid;
  logic             res_ready;

  // effective sizes, clamped to the supported range
  always_comb begin
    in9 = 9'(inputs_in_use);
    if (in9 == 9'd0) begin
      eff_in = 9'd1;
    end else if (in9 > 9'(MAX_INPUTS)) begin
      eff_in = 9'(MAX_INPUTS);
    end else begin
      eff_in = in9;
    end
    out7 = 7'(outputs_in_use);
    if (out7 == 7'd0) begin
      out_clamp = 7'd1;
    end else if (out7 > 7'(MAX_OUTPUTS)) begin
      out_clamp = 7'(MAX_OUTPUTS);
    end else begin
      out_clamp = out7;
    end
    eff_out = out_clamp[4:0];
  end

  // input word decode
  assign s_axis_tready = !mac_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = dlm_op_t'(s_axis_tuser);
  assign in_row        = s_axis_tdata[3:0];
  assign in_col        = s_axis_tdata[9:4];
  assign in_val        = s_axis_tdata[25:10];

  always_comb begin
    w_we    = 1'b0;
    b_we    = 1'b0;
    elem_go = 1'b0;
    case (op)
      OP_WEIGHT: begin
        w_we = in_fire && (7'(in_row) < 7'(MAX_OUTPUTS)) && (9'(in_col) < 9'(MAX_INPUTS));
      end
      OP_BIAS: begin
        b_we = in_fire && (7'(in_row) < 7'(MAX_OUTPUTS));
      end
      OP_ELEMENT: begin
        elem_go = in_fire;
      end
      default: begin
        w_we    = 1'b0;
      end
    endcase
  end

  // element bookkeeping
  always_comb begin
    cnt9         = 9'(count);
    cnt_inc      = (count == CNT_MAX) ? count : count + 1'b1;
    cmd.x        = in_val;
    cmd.first    = (count == '0);
    cmd.use_elem = (cnt9 < eff_in);
    cmd.last     = s_axis_tlast;
    cmd.size_err = (9'(cnt_inc) != eff_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (elem_go) begin
      count <= s_axis_tlast ? '0 : cnt_inc;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use  <= INPUTS_RST;
      outputs_in_use <= OUTPUTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dlm_reg_t'(cfg_index))
        REG_INPUTS:  inputs_in_use  <= cfg_data;
        REG_OUTPUTS: outputs_in_use <= cfg_data[4:0];
        default: begin
          inputs_in_use <= inputs_in_use;
        end
      endcase
    end
  end

  dlm_param_store #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_store (
    .clk       (clk),
    .w_we      (w_we),
    .w_row     (RW'(in_row)),
    .w_col     (CW'(in_col)),
    .w_data    (in_val),
    .b_we      (b_we),
    .b_row     (RW'(in_row)),
    .b_data    (in_val),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .rd_weight (rd_weight),
    .rd_bias   (rd_bias)
  );

  dlm_mac #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .start     (elem_go),
    .cmd       (cmd),
    .col       (cnt9[CW-1:0]),
    .nout      (eff_out),
    .busy      (mac_busy),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .rd_weight (rd_weight),
    .rd_bias   (rd_bias),
    .res       (mac_res),
    .res_valid (mac_res_valid),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (mac_res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {4'b0, mac_res.value, mac_res.index};
      m_axis_tuser  <= {mac_res.size_err, mac_res.sat};
      m_axis_tlast  <= mac_res.eov;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // an accepted element always starts a sweep
  a_elem_starts: assert property (@(posedge clk) disable iff (rst)
    elem_go |=> mac_busy)
    else $error("element accepted without starting a sweep");

  // handing over the last row of a vector frees the engine
  a_eov_idle: assert property (@(posedge clk) disable iff (rst)
    mac_res_valid && res_ready && mac_res.eov |=> !mac_busy)
    else $error("engine still busy after last result row");

  // a handed-over row shows up on the output
  a_res_lands: assert property (@(posedge clk) disable iff (rst)
    mac_res_valid && res_ready |=> m_axis_tvalid)
    else $error("result row lost between engine and output register");

endmodule

`default_nettype wire
